// ----- hdl/srv_pkg.sv -----
// ----------------------------------------------------------------------------
// Share recombination package
// Types, constants and the modulus for Lagrange recombination modulo l.
// ----------------------------------------------------------------------------
package srv_pkg;

    localparam int MAX_DEALERS  = 16;
    localparam int SCALAR_WORDS = 4;
    localparam int SLOT_W       = $clog2(MAX_DEALERS);
    localparam int POS_W        = $clog2(SCALAR_WORDS);
    localparam int STORE_W      = SLOT_W + POS_W;
    localparam int CNT_W        = 7;
    localparam int SW           = 256;
    localparam int MUL_CNT_W    = 8;

    localparam logic [SW-1:0] ORDER_L =
        256'h1000000000000000_0000000000000000_14def9dea2f79cd6_5812631a5cf5d3ed;

    localparam logic [1:0] REG_DEALER_COUNT = 2'd0;
    localparam logic [1:0] REG_PEER_INDEX   = 2'd1;

    // Operations of the shared modular arithmetic unit.
    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_SUB = 2'd1,
        OP_INV = 2'd2,
        OP_ADD = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_cmd_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_DUP_I,
        ST_DUP_CMP,
        ST_W_INIT,
        ST_W_J,
        ST_W_NUM,
        ST_W_NUM_WAIT,
        ST_W_SUB,
        ST_W_SUB_WAIT,
        ST_W_DEN,
        ST_W_DEN_WAIT,
        ST_W_INV,
        ST_W_INV_WAIT,
        ST_W_WT,
        ST_W_WT_WAIT,
        ST_S_INIT,
        ST_S_RED,
        ST_S_MUL,
        ST_S_MUL_WAIT,
        ST_S_ADD,
        ST_S_ADD_WAIT,
        ST_EMIT
    } seq_state_t;

    typedef enum logic [2:0] {
        AS_IDLE,
        AS_MUL,
        AS_INV_EVEN,
        AS_INV_STEP,
        AS_DONE
    } alu_state_t;

endpackage

// ----- hdl/srv_alu.sv -----
// ----------------------------------------------------------------------------
// Shared modular arithmetic unit
// Multiply (bit serial double and add), add, subtract and binary inversion
// modulo l, one step per cycle.
// ----------------------------------------------------------------------------
module srv_alu (
    input  logic                   clk,
    input  logic                   rst_n,
    input  srv_pkg::alu_cmd_t      cmd,
    input  logic [srv_pkg::SW-1:0] op_a,
    input  logic [srv_pkg::SW-1:0] op_b,
    output logic [srv_pkg::SW-1:0] res,
    output logic                   done
);
    import srv_pkg::*;

    alu_state_t          state_reg, state_next;
    logic [SW-1:0]       acc_reg, acc_next;
    logic [SW-1:0]       a_reg, a_next;
    logic [SW-1:0]       b_reg, b_next;
    logic [SW-1:0]       x1_reg, x1_next;
    logic [SW-1:0]       x2_reg, x2_next;
    logic [MUL_CNT_W-1:0] bit_reg, bit_next;

    logic [SW:0]   dbl, dbl_sub, add_s, add_s_sub, sub_d, sub_fix;
    logic [SW:0]   uv_d, x_sub, x_fix, h1, h2;
    logic [SW-1:0] dbl_m, dadd_m;
    logic [SW:0]   dadd, dadd_sub;
    logic          u_one, v_one;

    // Double, then conditionally add a, both reduced mod l; also the add, subtract and inversion terms.
    always_comb
    begin
        dbl      = {acc_reg, 1'b0};
        dbl_sub  = dbl - {1'b0, ORDER_L};
        dbl_m    = dbl_sub[SW] ? dbl[SW-1:0] : dbl_sub[SW-1:0];
        dadd     = {1'b0, dbl_m} + {1'b0, a_reg};
        dadd_sub = dadd - {1'b0, ORDER_L};
        dadd_m   = dadd_sub[SW] ? dadd[SW-1:0] : dadd_sub[SW-1:0];
        add_s     = {1'b0, op_a} + {1'b0, op_b};
        add_s_sub = add_s - {1'b0, ORDER_L};
        sub_d   = {1'b0, op_a} - {1'b0, op_b};
        sub_fix = sub_d + {1'b0, ORDER_L};
        uv_d  = {1'b0, a_reg} - {1'b0, b_reg};
        x_sub = uv_d[SW] ? ({1'b0, x2_reg} - {1'b0, x1_reg})
                         : ({1'b0, x1_reg} - {1'b0, x2_reg});
        x_fix = x_sub[SW] ? (x_sub + {1'b0, ORDER_L}) : x_sub;
        h1 = x1_reg[0] ? ({1'b0, x1_reg} + {1'b0, ORDER_L}) : {1'b0, x1_reg};
        h2 = x2_reg[0] ? ({1'b0, x2_reg} + {1'b0, ORDER_L}) : {1'b0, x2_reg};
        u_one = (a_reg == SW'(1));
        v_one = (b_reg == SW'(1));
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        x1_next    = x1_reg;
        x2_next    = x2_reg;
        bit_next   = bit_reg;
        case (state_reg)
            AS_IDLE:
            begin
                if (cmd.start)
                begin
                    case (cmd.op)
                        OP_MUL:
                        begin
                            acc_next   = '0;
                            a_next     = op_a;
                            b_next     = op_b;
                            bit_next   = MUL_CNT_W'(252);
                            state_next = AS_MUL;
                        end
                        OP_ADD:
                        begin
                            acc_next   = add_s_sub[SW] ? add_s[SW-1:0] : add_s_sub[SW-1:0];
                            state_next = AS_DONE;
                        end
                        OP_SUB:
                        begin
                            acc_next   = sub_d[SW] ? sub_fix[SW-1:0] : sub_d[SW-1:0];
                            state_next = AS_DONE;
                        end
                        OP_INV:
                        begin
                            a_next  = op_a;
                            b_next  = ORDER_L;
                            x1_next = SW'(1);
                            x2_next = '0;
                            if (op_a == '0)
                            begin
                                acc_next   = '0;
                                state_next = AS_DONE;
                            end
                            else
                            begin
                                state_next = AS_INV_EVEN;
                            end
                        end
                        default:
                        begin
                            state_next = AS_IDLE;
                        end
                    endcase
                end
            end
            AS_MUL:
            begin
                acc_next = b_reg[bit_reg] ? dadd_m : dbl_m;
                if (bit_reg == '0)
                    state_next = AS_DONE;
                else
                    bit_next = bit_reg - 1'b1;
            end
            AS_INV_EVEN:
            begin
                // Termination checked at loop head, as in binary Euclid.
                if (u_one || v_one)
                begin
                    acc_next   = u_one ? x1_reg : x2_reg;
                    state_next = AS_DONE;
                end
                else if (!a_reg[0])
                begin
                    a_next  = a_reg >> 1;
                    x1_next = h1[SW:1];
                end
                else if (!b_reg[0])
                begin
                    b_next  = b_reg >> 1;
                    x2_next = h2[SW:1];
                end
                else
                begin
                    state_next = AS_INV_STEP;
                end
            end
            AS_INV_STEP:
            begin
                if (!uv_d[SW])
                begin
                    a_next  = uv_d[SW-1:0];
                    x1_next = x_fix[SW-1:0];
                end
                else
                begin
                    b_next  = b_reg - a_reg;
                    x2_next = x_fix[SW-1:0];
                end
                state_next = AS_INV_EVEN;
            end
            AS_DONE:
            begin
                state_next = AS_IDLE;
            end
            default:
            begin
                state_next = AS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res  = acc_reg;
        done = (state_reg == AS_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= AS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        x1_reg  <= x1_next;
        x2_reg  <= x2_next;
        bit_reg <= bit_next;
    end

`ifndef NO_ASSERTIONS
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == AS_DONE |=> state_reg == AS_IDLE)
        else $error("alu done held");
    a_mul_bits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == AS_MUL && bit_reg != '0 |=> state_reg == AS_MUL)
        else $error("alu multiply ended early");
    a_res_red: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> res < ORDER_L)
        else $error("alu result not reduced");
`endif

endmodule

// ----- hdl/share_recombine_vandermonde.sv -----
// ----------------------------------------------------------------------------
// Share recombination by Lagrange interpolation at zero
// Collects dealer shares, derives the weights at zero modulo l and emits
// the weighted sum as four words.
// ----------------------------------------------------------------------------
//  Channel   | Signals                                        | Direction
//  ----------+------------------------------------------------+----------
//  input     | in_valid/in_ready, dealer_index, word_number,   | in
//            | share_word                                     |
//  output    | out_valid/out_ready, result_peer, ...           | out
//  config    | psel, penable, pwrite, paddr, pwdata, prdata    | in/out
//
// A word that does not complete a run is taken with in_ready left high for the
// next. The final word starts the sequencer over the shared modular unit:
// about 2*n*n multiplications plus one inversion per dealer, all on the single
// bit-serial unit. in_ready stays low until the four result items are taken;
// the output side stalls freely. Reset is asynchronous.
module share_recombine_vandermonde (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  dealer_index,
    input  logic [1:0]  word_number,
    input  logic [63:0] share_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  result_peer,
    output logic [1:0]  result_word_number,
    output logic [63:0] result_word,
    output logic        last_word,
    output logic        singular_error
);
    import srv_pkg::*;

    seq_state_t state_reg, state_next;

    logic [4:0]        dealer_count_reg;
    logic [7:0]        peer_index_reg;
    logic [CNT_W-1:0]  words_reg, words_next;
    logic [SLOT_W:0]   n_eff;

    logic [7:0]  point_mem [MAX_DEALERS];
    logic [63:0] share_mem [MAX_DEALERS*SCALAR_WORDS];
    logic [SW-1:0] weight_mem [MAX_DEALERS];

    logic [SLOT_W:0] i_reg, i_next, j_reg, j_next;
    logic [SW-1:0]   num_reg, num_next, den_reg, den_next;
    logic [SW-1:0]   t_reg, t_next, sum_reg, sum_next;
    logic [1:0]      k_reg, k_next;
    logic            err_reg, err_next;
    logic [POS_W:0]  rd_pos_reg, rd_pos_next;

    alu_cmd_t      cmd;
    logic [SW-1:0] op_a, op_b, alu_res;
    logic          alu_done;

    logic          in_fire, cfg_wr, run_done;
    logic [SLOT_W-1:0] slot;
    logic [7:0]    pi_rd, pj_rd;
    logic [63:0]   sh_rd_reg;
    logic [SW-1:0] w_rd_reg;

    srv_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .op_a  (op_a),
        .op_b  (op_b),
        .res   (alu_res),
        .done  (alu_done)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_DEALER_COUNT[0]: prdata = {27'd0, dealer_count_reg};
            default:             prdata = {24'd0, peer_index_reg};
        endcase
    end

    always_comb
    begin
        if (dealer_count_reg == 5'd0)
            n_eff = (SLOT_W+1)'(1);
        else if (dealer_count_reg > 5'(MAX_DEALERS))
            n_eff = (SLOT_W+1)'(MAX_DEALERS);
        else
            n_eff = (SLOT_W+1)'(dealer_count_reg);
    end

    assign in_ready = (state_reg == ST_LOAD);
    assign in_fire  = in_valid && in_ready;
    assign slot     = words_reg[SLOT_W+1:2];
    assign words_next = words_reg + 1'b1;
    assign run_done = ({1'b0, words_next} >= {(CNT_W+1-SLOT_W-3)'(0), n_eff, 2'b00});

    // Combinational reads of the point store at the sequencer's indexes.
    assign pi_rd = point_mem[i_reg[SLOT_W-1:0]];
    assign pj_rd = point_mem[j_reg[SLOT_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (in_fire && words_reg[CNT_W-1:SLOT_W+2] == '0)
        begin
            point_mem[slot] <= dealer_index;
            share_mem[{slot, word_number}] <= share_word;
        end
        if (state_reg == ST_W_WT_WAIT && alu_done)
            weight_mem[i_reg[SLOT_W-1:0]] <= alu_res;
        // The read addresses follow the next indexes, so the data matches
        // the current indexes in the cycle that uses it.
        sh_rd_reg <= share_mem[{i_next[SLOT_W-1:0], rd_pos_next[POS_W-1:0]}];
        w_rd_reg  <= weight_mem[i_next[SLOT_W-1:0]];
    end

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        t_next      = t_reg;
        sum_next    = sum_reg;
        k_next      = k_reg;
        err_next    = err_reg;
        rd_pos_next = rd_pos_reg;
        cmd.start   = 1'b0;
        cmd.op      = OP_MUL;
        op_a        = num_reg;
        op_b        = den_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && run_done)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    err_next   = 1'b0;
                    state_next = ST_DUP_I;
                end
            end
            ST_DUP_I:
            begin
                if (i_reg == n_eff)
                begin
                    i_next     = '0;
                    state_next = ST_W_INIT;
                end
                else
                begin
                    j_next     = '0;
                    state_next = ST_DUP_CMP;
                end
            end
            ST_DUP_CMP:
            begin
                if (j_reg == i_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_DUP_I;
                end
                else if (pi_rd == pj_rd)
                begin
                    err_next   = 1'b1;
                    sum_next   = '0;
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_W_INIT:
            begin
                if (i_reg == n_eff)
                begin
                    i_next      = '0;
                    sum_next    = '0;
                    rd_pos_next = '0;
                    state_next  = ST_S_INIT;
                end
                else
                begin
                    num_next   = SW'(1);
                    den_next   = SW'(1);
                    j_next     = '0;
                    state_next = ST_W_J;
                end
            end
            ST_W_J:
            begin
                if (j_reg == n_eff)
                    state_next = ST_W_INV;
                else if (j_reg == i_reg)
                    j_next = j_reg + 1'b1;
                else
                    state_next = ST_W_NUM;
            end
            ST_W_NUM:
            begin
                cmd.start  = 1'b1;
                op_a       = num_reg;
                op_b       = SW'(pj_rd);
                state_next = ST_W_NUM_WAIT;
            end
            ST_W_NUM_WAIT:
            begin
                if (alu_done)
                begin
                    num_next   = alu_res;
                    state_next = ST_W_SUB;
                end
            end
            ST_W_SUB:
            begin
                cmd.start  = 1'b1;
                cmd.op     = OP_SUB;
                op_a       = SW'(pj_rd);
                op_b       = SW'(pi_rd);
                state_next = ST_W_SUB_WAIT;
            end
            ST_W_SUB_WAIT:
            begin
                if (alu_done)
                begin
                    t_next     = alu_res;
                    state_next = ST_W_DEN;
                end
            end
            ST_W_DEN:
            begin
                cmd.start  = 1'b1;
                op_a       = den_reg;
                op_b       = t_reg;
                state_next = ST_W_DEN_WAIT;
            end
            ST_W_DEN_WAIT:
            begin
                if (alu_done)
                begin
                    den_next   = alu_res;
                    j_next     = j_reg + 1'b1;
                    state_next = ST_W_J;
                end
            end
            ST_W_INV:
            begin
                cmd.start  = 1'b1;
                cmd.op     = OP_INV;
                op_a       = den_reg;
                state_next = ST_W_INV_WAIT;
            end
            ST_W_INV_WAIT:
            begin
                if (alu_done)
                begin
                    t_next     = alu_res;
                    state_next = ST_W_WT;
                end
            end
            ST_W_WT:
            begin
                cmd.start  = 1'b1;
                op_a       = num_reg;
                op_b       = t_reg;
                state_next = ST_W_WT_WAIT;
            end
            ST_W_WT_WAIT:
            begin
                if (alu_done)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_W_INIT;
                end
            end
            ST_S_INIT:
            begin
                // Gather the share one word per cycle.
                if (i_reg == n_eff)
                begin
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
                else if (rd_pos_reg == (POS_W+1)'(SCALAR_WORDS))
                begin
                    state_next = ST_S_RED;
                end
                else
                begin
                    t_next      = {sh_rd_reg, t_reg[SW-1:64]};
                    rd_pos_next = rd_pos_reg + 1'b1;
                end
            end
            ST_S_RED:
            begin
                // A 256-bit value is below 16*l, so at most 15 subtractions
                // bring it below l.
                if (t_reg >= ORDER_L)
                    t_next = t_reg - ORDER_L;
                else
                    state_next = ST_S_MUL;
            end
            ST_S_MUL:
            begin
                cmd.start  = 1'b1;
                op_a       = t_reg;
                op_b       = w_rd_reg;
                state_next = ST_S_MUL_WAIT;
            end
            ST_S_MUL_WAIT:
            begin
                if (alu_done)
                begin
                    t_next     = alu_res;
                    state_next = ST_S_ADD;
                end
            end
            ST_S_ADD:
            begin
                cmd.start  = 1'b1;
                cmd.op     = OP_ADD;
                op_a       = sum_reg;
                op_b       = t_reg;
                state_next = ST_S_ADD_WAIT;
            end
            ST_S_ADD_WAIT:
            begin
                if (alu_done)
                begin
                    sum_next    = alu_res;
                    i_next      = i_reg + 1'b1;
                    rd_pos_next = '0;
                    state_next  = ST_S_INIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    k_next = k_reg + 1'b1;
                    if (k_reg == 2'(SCALAR_WORDS - 1))
                        state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        out_valid          = (state_reg == ST_EMIT);
        result_peer        = peer_index_reg;
        result_word_number = k_reg;
        result_word        = sum_reg[64*k_reg +: 64];
        last_word          = (k_reg == 2'(SCALAR_WORDS - 1));
        singular_error     = err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            words_reg        <= '0;
            dealer_count_reg <= 5'd1;
            peer_index_reg   <= 8'd0;
            k_reg            <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            rd_pos_reg       <= '0;
            err_reg          <= 1'b0;
            sum_reg          <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            rd_pos_reg <= rd_pos_next;
            err_reg    <= err_next;
            sum_reg    <= sum_next;
            if (in_fire)
                words_reg <= run_done ? '0 : words_next;
            if (cfg_wr && paddr[2] == REG_DEALER_COUNT[0])
                dealer_count_reg <= pwdata[4:0];
            if (cfg_wr && paddr[2] == REG_PEER_INDEX[0])
                peer_index_reg <= pwdata[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        t_reg   <= t_next;
    end

`ifndef NO_ASSERTIONS
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_LOAD |-> !in_ready)
        else $error("item taken while busy");
    a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_word |=> state_reg == ST_LOAD)
        else $error("run did not close after last word");
    a_words_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> words_reg == '0)
        else $error("word count not cleared at run end");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular_error |-> result_word == 64'd0)
        else $error("singular run gave nonzero word");
`endif

endmodule
